/* hw/rtl/pfx_pkg.sv */
package pfx_pkg;

	localparam int StackDepth = 64;
	localparam int SpW = $clog2(StackDepth + 1);
	localparam int AddrW = $clog2(StackDepth);

	typedef enum logic [2:0] {
		CMD_PUSH = 3'd0,
		CMD_ADD  = 3'd1,
		CMD_SUB  = 3'd2,
		CMD_MUL  = 3'd3,
		CMD_DIV  = 3'd4,
		CMD_SQRT = 3'd5,
		CMD_MOD  = 3'd6,
		CMD_POW  = 3'd7
	} cmd_t;

	typedef enum logic [2:0] {
		ST_OK      = 3'd0,
		ST_UNDER   = 3'd1,
		ST_OVER    = 3'd2,
		ST_DIVZ    = 3'd3,
		ST_NEGROOT = 3'd4,
		ST_ZNEGPOW = 3'd5
	} status_t;

	typedef enum logic [9:0] {
		S_IDLE  = 10'b0000000001,
		S_RD1   = 10'b0000000010,
		S_RD2   = 10'b0000000100,
		S_CHK   = 10'b0000001000,
		S_DIV   = 10'b0000010000,
		S_SQRT  = 10'b0000100000,
		S_POW   = 10'b0001000000,
		S_MULW  = 10'b0010000000,
		S_WB    = 10'b0100000000,
		S_FIN   = 10'b1000000000
	} state_t;

endpackage

/* hw/rtl/postfix_expression_evaluator_core.sv */
// Postfix expression evaluator on a 32-bit signed operand stack.
// Input channel (in_valid / in_stall): one token per word, with cmd,
// operand and last. Output channel (out_valid / out_stall): one word
// (value, status) after each token marked last; no word otherwise.
// Each token runs through a small sequencer that reads the stack memory
// (one registered read port, one write port) and drives one shared
// 32-bit adder/subtractor plus one 32x32 multiplier.
// Divide and modulo take one quotient bit per cycle over 32 bits; square
// root one result bit per cycle over 16 bits; power works by
// square-and-multiply over the significant exponent bits, and a negative
// exponent is settled without the loop. A last token loads the result
// word in a final step; an error ends the token early.
// in_stall is high while a token is in work, so tokens are taken one at
// a time. The result sits in an output register; while out_stall holds
// it, only a following last token waits, in its final step.
// Reset clears the stack pointer, sticky error and control state; stack
// memory contents stay undefined and are never used before written.
// Errors are sticky until the last token, which reports the first error
// with value 0 and then empties the stack.
module postfix_expression_evaluator_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [2:0]         cmd,
	input  logic signed [31:0] operand,
	input  logic               last,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] value,
	output logic [2:0]         status
);

	localparam int SpW = pfx_pkg::SpW;
	localparam int AddrW = pfx_pkg::AddrW;

	pfx_pkg::state_t state_q;
	logic [SpW-1:0] sp_q;
	logic [2:0] err_q;
	logic [2:0] cmd_q;
	logic last_q;
	logic [31:0] opnd_q;

	// stack memory
	logic [31:0] mem [pfx_pkg::StackDepth];
	logic [31:0] rd_q;
	logic [AddrW-1:0] rd_addr;
	logic rd_en;
	logic [AddrW-1:0] wr_addr;
	logic wr_en;
	logic [31:0] wr_data;

	// forward a write landing on the address being read in the same cycle
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			if (wr_en && wr_addr == rd_addr) begin
				rd_q <= wr_data;
			end else begin
				rd_q <= mem[rd_addr];
			end
		end
	end

	// operands and work registers
	logic [31:0] a_q, b_q;       // a below, b top
	logic [31:0] res_q;
	logic [31:0] rem_q;          // divider remainder / sqrt remainder
	logic [31:0] quo_q;          // dividend shift / sqrt input
	logic [5:0] cnt_q;
	logic [31:0] acc_q, base_q, ex_q;
	logic pow_sq_q;              // power: 0 multiply step, 1 square step
	logic [31:0] mul_a, mul_b;
	logic [31:0] mul_p;
	logic [31:0] mul_q;
	logic neg_q, rneg_q;

	assign mul_p = mul_a * mul_b;

	// shared adder/subtractor
	logic [32:0] alu_x, alu_y, alu_r;
	logic alu_sub;
	assign alu_r = alu_sub ? (alu_x - alu_y) : (alu_x + alu_y);

	logic [31:0] abs_a, abs_b;
	assign abs_a = a_q[31] ? (~a_q + 32'd1) : a_q;
	assign abs_b = b_q[31] ? (~b_q + 32'd1) : b_q;

	// divider step: partial remainder shifted left with next dividend bit
	logic [32:0] div_trial;
	assign div_trial = {rem_q, quo_q[31]};

	// sqrt step (two bits of input per step)
	logic [33:0] sq_trial;
	assign sq_trial = {rem_q, quo_q[31:30]};

	logic [SpW-1:0] need;
	assign need = (cmd_q == pfx_pkg::CMD_SQRT) ? SpW'(1) : SpW'(2);

	always_comb begin
		alu_x = '0;
		alu_y = '0;
		alu_sub = 1'b0;
		mul_a = acc_q;
		mul_b = base_q;
		if (state_q == pfx_pkg::S_DIV) begin
			alu_x = div_trial;
			alu_y = {1'b0, abs_b};
			alu_sub = 1'b1;
		end else if (state_q == pfx_pkg::S_SQRT) begin
			// trial is four times the partial root plus one
			alu_x = sq_trial[32:0];
			alu_y = {res_q[30:0], 2'b01};
			alu_sub = 1'b1;
		end else begin
			alu_x = {1'b0, a_q};
			alu_y = {1'b0, b_q};
			alu_sub = (cmd_q == pfx_pkg::CMD_SUB);
		end
		if (state_q == pfx_pkg::S_CHK) begin
			mul_a = a_q;
			mul_b = b_q;
		end else if (pow_sq_q) begin
			mul_a = base_q;
			mul_b = base_q;
		end
	end

	assign in_stall = (state_q != pfx_pkg::S_IDLE);

	always_comb begin
		rd_en = 1'b0;
		rd_addr = '0;
		if (state_q == pfx_pkg::S_IDLE || state_q == pfx_pkg::S_RD1) begin
			rd_en = 1'b1;
			rd_addr = (state_q == pfx_pkg::S_IDLE) ? AddrW'(sp_q - SpW'(1))
				: AddrW'(sp_q - SpW'(2));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pfx_pkg::S_IDLE;
			sp_q <= '0;
			err_q <= pfx_pkg::ST_OK;
			out_valid <= 1'b0;
			wr_en <= 1'b0;
			pow_sq_q <= 1'b0;
		end else begin
			wr_en <= 1'b0;
			if (out_valid && !out_stall && state_q != pfx_pkg::S_FIN) begin
				out_valid <= 1'b0;
			end
			unique case (state_q)
				pfx_pkg::S_IDLE: begin
					if (in_valid && !in_stall) begin
						cmd_q <= cmd;
						opnd_q <= operand;
						last_q <= last;
						if (err_q != pfx_pkg::ST_OK) begin
							state_q <= last ? pfx_pkg::S_FIN : pfx_pkg::S_IDLE;
						end else if (cmd == pfx_pkg::CMD_PUSH) begin
							if (sp_q >= SpW'(pfx_pkg::StackDepth)) begin
								err_q <= pfx_pkg::ST_OVER;
							end else begin
								wr_en <= 1'b1;
								wr_addr <= AddrW'(sp_q);
								wr_data <= operand;
								sp_q <= sp_q + SpW'(1);
							end
							state_q <= last ? pfx_pkg::S_WB : pfx_pkg::S_IDLE;
						end else begin
							state_q <= pfx_pkg::S_RD1;
						end
					end
				end
				pfx_pkg::S_RD1: begin
					b_q <= rd_q;
					if (sp_q < need) begin
						err_q <= pfx_pkg::ST_UNDER;
						state_q <= last_q ? pfx_pkg::S_FIN : pfx_pkg::S_IDLE;
					end else if (cmd_q == pfx_pkg::CMD_SQRT) begin
						if (rd_q[31]) begin
							err_q <= pfx_pkg::ST_NEGROOT;
							state_q <= last_q ? pfx_pkg::S_FIN : pfx_pkg::S_IDLE;
						end else begin
							quo_q <= rd_q;
							rem_q <= '0;
							res_q <= '0;
							cnt_q <= 6'd16;
							state_q <= pfx_pkg::S_SQRT;
						end
					end else begin
						state_q <= pfx_pkg::S_RD2;
					end
				end
				pfx_pkg::S_RD2: begin
					a_q <= rd_q;
					state_q <= pfx_pkg::S_CHK;
				end
				pfx_pkg::S_CHK: begin
					state_q <= pfx_pkg::S_WB;
					unique case (cmd_q)
						pfx_pkg::CMD_ADD, pfx_pkg::CMD_SUB: res_q <= alu_r[31:0];
						pfx_pkg::CMD_MUL: begin
							mul_q <= mul_p[31:0];
							state_q <= pfx_pkg::S_MULW;
						end
						pfx_pkg::CMD_DIV, pfx_pkg::CMD_MOD: begin
							if (b_q == 32'd0) begin
								err_q <= pfx_pkg::ST_DIVZ;
								state_q <= last_q ? pfx_pkg::S_FIN : pfx_pkg::S_IDLE;
							end else begin
								quo_q <= abs_a;
								rem_q <= '0;
								cnt_q <= 6'd32;
								neg_q <= a_q[31] ^ b_q[31];
								rneg_q <= a_q[31];
								state_q <= pfx_pkg::S_DIV;
							end
						end
						pfx_pkg::CMD_POW: begin
							if (b_q[31]) begin
								if (a_q == 32'd0) begin
									err_q <= pfx_pkg::ST_ZNEGPOW;
									state_q <= last_q ? pfx_pkg::S_FIN : pfx_pkg::S_IDLE;
								end else if (a_q == 32'd1) begin
									res_q <= 32'd1;
								end else if (a_q == 32'hFFFF_FFFF) begin
									res_q <= b_q[0] ? 32'hFFFF_FFFF : 32'd1;
								end else begin
									res_q <= 32'd0;
								end
							end else begin
								acc_q <= 32'd1;
								base_q <= a_q;
								ex_q <= b_q;
								pow_sq_q <= 1'b0;
								state_q <= pfx_pkg::S_POW;
							end
						end
						default: res_q <= '0;
					endcase
				end
				pfx_pkg::S_MULW: begin
					res_q <= mul_q;
					state_q <= pfx_pkg::S_WB;
				end
				pfx_pkg::S_DIV: begin
					// restoring division, one quotient bit per cycle
					if (!alu_r[32]) begin
						rem_q <= alu_r[31:0];
						quo_q <= {quo_q[30:0], 1'b1};
					end else begin
						rem_q <= div_trial[31:0];
						quo_q <= {quo_q[30:0], 1'b0};
					end
					cnt_q <= cnt_q - 6'd1;
					if (cnt_q == 6'd1) begin
						state_q <= pfx_pkg::S_MULW;
						pow_sq_q <= 1'b0;
					end
				end
				pfx_pkg::S_SQRT: begin
					// digit-by-digit root, one result bit per cycle
					if (sq_trial[33] == 1'b0 && !alu_r[32]) begin
						rem_q <= alu_r[31:0];
						res_q <= {res_q[30:0], 1'b1};
					end else begin
						rem_q <= sq_trial[31:0];
						res_q <= {res_q[30:0], 1'b0};
					end
					quo_q <= {quo_q[29:0], 2'b00};
					cnt_q <= cnt_q - 6'd1;
					if (cnt_q == 6'd1) begin
						state_q <= pfx_pkg::S_WB;
					end
				end
				pfx_pkg::S_POW: begin
					if (pow_sq_q) begin
						base_q <= mul_p[31:0];
						ex_q <= {1'b0, ex_q[31:1]};
						pow_sq_q <= 1'b0;
					end else if (ex_q == 32'd0) begin
						res_q <= acc_q;
						state_q <= pfx_pkg::S_WB;
					end else begin
						if (ex_q[0]) begin
							acc_q <= mul_p[31:0];
						end
						pow_sq_q <= 1'b1;
					end
				end
				pfx_pkg::S_WB: begin
					if (cmd_q != pfx_pkg::CMD_PUSH) begin
						wr_en <= 1'b1;
						if (cmd_q == pfx_pkg::CMD_SQRT) begin
							wr_addr <= AddrW'(sp_q - SpW'(1));
						end else begin
							wr_addr <= AddrW'(sp_q - SpW'(2));
							sp_q <= sp_q - SpW'(1);
						end
						wr_data <= res_q;
						res_q <= res_q;
					end else begin
						res_q <= opnd_q;
					end
					state_q <= last_q ? pfx_pkg::S_FIN : pfx_pkg::S_IDLE;
				end
				pfx_pkg::S_FIN: begin
					// top of stack is the word just written (or pushed);
					// hold here while the previous word is still stalled
					if (!out_valid || !out_stall) begin
						out_valid <= 1'b1;
						if (err_q != pfx_pkg::ST_OK) begin
							value <= '0;
							status <= err_q;
						end else if (sp_q == '0) begin
							value <= '0;
							status <= pfx_pkg::ST_UNDER;
						end else begin
							value <= res_q;
							status <= pfx_pkg::ST_OK;
						end
						sp_q <= '0;
						err_q <= pfx_pkg::ST_OK;
						state_q <= pfx_pkg::S_IDLE;
					end
				end
				default: state_q <= pfx_pkg::S_IDLE;
			endcase
			// division result: pick quotient or remainder with signs
			if (state_q == pfx_pkg::S_DIV && cnt_q == 6'd1) begin
				if (cmd_q == pfx_pkg::CMD_DIV) begin
					mul_q <= neg_q ? (~{quo_q[30:0], !alu_r[32]} + 32'd1)
						: {quo_q[30:0], !alu_r[32]};
				end else begin
					mul_q <= rneg_q ? (~(alu_r[32] ? div_trial[31:0] : alu_r[31:0]) + 32'd1)
						: (alu_r[32] ? div_trial[31:0] : alu_r[31:0]);
				end
			end
		end
	end

	// Tokens that must surface the top of stack without computing (a last
	// push with no error leaves res_q = operand via S_WB; an error-free
	// last token that skipped work is impossible: all paths pass S_WB).

	assert property (@(posedge clk) disable iff (!arst_n)
		sp_q <= SpW'(pfx_pkg::StackDepth))
		else $error("stack pointer beyond depth");

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != pfx_pkg::S_IDLE) |-> in_stall)
		else $error("token accepted while busy");

	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status != pfx_pkg::ST_OK) |-> (value == 32'd0))
		else $error("error word carries a value");

	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> ($past(state_q) == pfx_pkg::S_FIN))
		else $error("result word outside final step");

endmodule
